// ===== src/fupb_pkg.sv =====
// Shared types and constants for the frame unpacker with XOR check byte.
// Used by fupb_parse and frame_unpack_params_bcc_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fupb_pkg;

	// final frame status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FORMAT = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;

	// a data length at or below this is a format error
	localparam logic [15:0] MIN_LEN     = 16'd5;
	// byte position of the first parameter byte (after the two status bytes)
	localparam logic [16:0] PARAM_START = 17'd8;
	localparam logic [16:0] STAT_POS_A  = 17'd6;
	localparam logic [16:0] STAT_POS_B  = 17'd7;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  param_index;
		logic [15:0] param_length;
		logic        byte_valid;
		logic [7:0]  data_byte;
		logic        last_of_param;
		logic [1:0]  status;
	} fupb_item_t;

	typedef struct packed {
		logic       valid;
		fupb_item_t item;
	} fupb_res_t;

endpackage

`default_nettype wire

// ===== src/fupb_if.sv =====
// Valid/ready channel interfaces for the frame unpacker: received bytes in,
// parameter and status words out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface fupb_in_if;
	logic       valid;
	logic       ready;
	logic       frame_start;
	logic [7:0] rx_byte;

	modport source(output valid, output frame_start, output rx_byte, input ready);
	modport sink(input valid, input frame_start, input rx_byte, output ready);
endinterface

interface fupb_out_if;
	logic        valid;
	logic        ready;
	logic        is_status;
	logic [7:0]  param_index;
	logic [15:0] param_length;
	logic        byte_valid;
	logic [7:0]  data_byte;
	logic        last_of_param;
	logic [1:0]  status;

	modport source(output valid, output is_status, output param_index,
		output param_length, output byte_valid, output data_byte,
		output last_of_param, output status, input ready);
	modport sink(input valid, input is_status, input param_index,
		input param_length, input byte_valid, input data_byte,
		input last_of_param, input status, output ready);
endinterface

`default_nettype wire

// ===== src/fupb_parse.sv =====
// Frame parser: tracks position, length, running XOR and parameter state,
// and forms any result word for an accepted byte. Depends on fupb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fupb_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              frame_start,
	input  wire logic [7:0]        rx_byte,
	input  wire logic [7:0]        param_count,
	output fupb_pkg::fupb_res_t    res
);
	import fupb_pkg::*;

	localparam logic [1:0] PH_LEN_HI = 2'd0;
	localparam logic [1:0] PH_LEN_LO = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	logic [16:0] pos_q,   pos_d;
	logic [15:0] flen_q,  flen_d;
	logic [7:0]  bcc_q,   bcc_d;
	logic        sbz_q,   sbz_d;
	logic [7:0]  pdone_q, pdone_d;
	logic [1:0]  phase_q, phase_d;
	logic [15:0] plen_q,  plen_d;
	logic [15:0] prem_q,  prem_d;
	logic        active_q, active_d;

	logic        in_data;
	logic [15:0] plen_lo;
	logic [15:0] prem_dec;

	assign in_data  = pos_q <= ({1'b0, flen_q} + 17'd2);
	assign plen_lo  = {plen_q[15:8], rx_byte};
	assign prem_dec = prem_q - 16'd1;

	always_comb begin
		pos_d    = pos_q;
		flen_d   = flen_q;
		bcc_d    = bcc_q;
		sbz_d    = sbz_q;
		pdone_d  = pdone_q;
		phase_d  = phase_q;
		plen_d   = plen_q;
		prem_d   = prem_q;
		active_d = active_q;
		res      = '0;

		if (frame_start) begin
			pos_d    = 17'd1;
			flen_d   = '0;
			bcc_d    = '0;
			sbz_d    = 1'b1;
			pdone_d  = '0;
			phase_d  = PH_LEN_HI;
			plen_d   = '0;
			prem_d   = '0;
			active_d = 1'b1;
		end else if (active_q) begin
			pos_d = pos_q + 17'd1;
			if (pos_q == 17'd1) begin
				flen_d = {rx_byte, 8'h00};
			end else if (pos_q == 17'd2) begin
				flen_d = {flen_q[15:8], rx_byte};
			end else if (in_data) begin
				bcc_d = bcc_q ^ rx_byte;
				if ((pos_q == STAT_POS_A || pos_q == STAT_POS_B) && rx_byte != 8'h00)
					sbz_d = 1'b0;
				if (pos_q >= PARAM_START && sbz_q && pdone_q < param_count) begin
					unique case (phase_q)
						PH_LEN_HI: begin
							plen_d  = {rx_byte, 8'h00};
							phase_d = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							plen_d = plen_lo;
							prem_d = plen_lo;
							if (plen_lo == 16'd0) begin
								// empty parameter: one marker word
								res.valid              = 1'b1;
								res.item.param_index   = pdone_q;
								res.item.last_of_param = 1'b1;
								pdone_d = pdone_q + 8'd1;
								phase_d = PH_LEN_HI;
							end else begin
								phase_d = PH_DATA;
							end
						end
						default: begin
							prem_d                 = prem_dec;
							res.valid              = 1'b1;
							res.item.param_index   = pdone_q;
							res.item.param_length  = plen_q;
							res.item.byte_valid    = 1'b1;
							res.item.data_byte     = rx_byte;
							res.item.last_of_param = (prem_dec == 16'd0);
							if (prem_dec == 16'd0) begin
								pdone_d = pdone_q + 8'd1;
								phase_d = PH_LEN_HI;
							end
						end
					endcase
				end
			end else begin
				// check byte: close the frame with its status
				res.valid          = 1'b1;
				res.item.is_status = 1'b1;
				priority if (!sbz_q || flen_q <= MIN_LEN)
					res.item.status = ST_FORMAT;
				else if (bcc_q != rx_byte)
					res.item.status = ST_CHECK;
				else
					res.item.status = ST_OK;
				pos_d    = pos_q;
				active_d = 1'b0;
			end
		end

		if (!accept)
			res.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			flen_q   <= '0;
			bcc_q    <= '0;
			sbz_q    <= 1'b1;
			pdone_q  <= '0;
			phase_q  <= PH_LEN_HI;
			plen_q   <= '0;
			prem_q   <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_d;
			flen_q   <= flen_d;
			bcc_q    <= bcc_d;
			sbz_q    <= sbz_d;
			pdone_q  <= pdone_d;
			phase_q  <= phase_d;
			plen_q   <= plen_d;
			prem_q   <= prem_d;
			active_q <= active_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/frame_unpack_params_bcc_top.sv =====
// Channel    Dir  Word
// in_ch      in   frame_start, rx_byte
// out_ch     out  is_status, param_index, param_length, byte_valid, data_byte,
//                 last_of_param, status
// cfg        in   cfg_we / cfg_wdata -> param_count
//
// One byte is accepted per cycle while in_ch.ready is high; its word (if
// any) appears in the output register on the next cycle. The only per-byte
// path is fupb_parse: counter, XOR and compare updates. in_ch.ready drops
// only while the output register holds a word that out_ch does not take.
// Reset clears the frame state and param_count; a frame then starts at a
// byte with frame_start set. Depends on fupb_pkg, fupb_if and fupb_parse.
`timescale 1ns / 1ps
`default_nettype none

module frame_unpack_params_bcc_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fupb_in_if.sink    in_ch,
	fupb_out_if.source out_ch,
	input  wire logic  cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	import fupb_pkg::*;

	logic [7:0] pcount_val_q;
	logic       in_acc;
	fupb_res_t  res;
	logic       out_valid_q;
	fupb_item_t out_item_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_val_q <= '0;
		end else if (cfg_we) begin
			pcount_val_q <= cfg_wdata;
		end
	end

	fupb_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.frame_start (in_ch.frame_start),
		.rx_byte     (in_ch.rx_byte),
		.param_count (pcount_val_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res.valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: load only when a new word is produced
	always_ff @(posedge clk) begin
		if (in_acc && res.valid) begin
			out_item_q <= res.item;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.is_status     = out_item_q.is_status;
	assign out_ch.param_index   = out_item_q.param_index;
	assign out_ch.param_length  = out_item_q.param_length;
	assign out_ch.byte_valid    = out_item_q.byte_valid;
	assign out_ch.data_byte     = out_item_q.data_byte;
	assign out_ch.last_of_param = out_item_q.last_of_param;
	assign out_ch.status        = out_item_q.status;

`ifndef SYNTH
	a_status_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.is_status |-> out_item_q.param_index == 8'd0
		&& out_item_q.param_length == 16'd0 && !out_item_q.byte_valid
		&& out_item_q.data_byte == 8'd0 && !out_item_q.last_of_param)
		else $error("status word carries parameter fields");

	a_param_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_item_q.is_status |-> out_item_q.status == ST_OK)
		else $error("parameter word carries a status code");

	a_marker_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_item_q.is_status && !out_item_q.byte_valid
		|-> out_item_q.last_of_param && out_item_q.param_length == 16'd0
		&& out_item_q.data_byte == 8'd0)
		else $error("empty parameter marker malformed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_item_q))
		else $error("pending word lost or changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with an empty output register");
`endif

endmodule

`default_nettype wire
